[rtl/jls_pkg.sv]
// Shared types and constants for the Jacobi linear solver.
// Used by the controller, the datapath and the top level; no dependencies.
package jls_pkg;

    // Request codes.
    localparam logic [1:0] REQ_COEF  = 2'd0;
    localparam logic [1:0] REQ_RHS   = 2'd1;
    localparam logic [1:0] REQ_GUESS = 2'd2;
    localparam logic [1:0] REQ_START = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ORDER = 2'd0;
    localparam logic [1:0] CFG_TOL   = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    localparam int CFG_W = 31;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [5:0]         elem_index;
        logic signed [31:0] solution;
        logic [15:0]        sweeps_done;
        logic [1:0]         status;
        logic               last_item;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       diag_rd;    // read diagonal entry at row i
        logic       diag_chk;   // registered diagonal is valid, check for zero
        logic       row_init;   // load accumulator from rhs[i]
        logic       mac_rd;     // read A[i][j] and x_prev[j]
        logic       mac_acc;    // accumulate the registered product term
        logic       div_start;  // start the divider for row i
        logic       copy_rd;    // read x_cur[i] for copy into x_prev
        logic       copy_wr;    // write registered x_cur into x_prev
        logic       sweep_clr;  // clear max change at sweep start
        logic       out_rd;     // read x_cur[i] for output
        logic [5:0] i;
        logic [5:0] j;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_diag;
        logic div_done;
        logic converged;
    } dp_stat_t;

endpackage

[rtl/jls_divider.sv]
// Restoring divider for Q16.16 quotients, one quotient bit per cycle.
// Depends on nothing beyond its ports.
module jls_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [55:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quot
);
    // A numerator magnitude of 2^47 or more always saturates, since the divisor
    // is at most 2^31. Below that |num|*2^16 fits in 64 bits; 64 iterations
    // produce the magnitude.
    logic [63:0] dvd_reg, dvd_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic        neg_reg, neg_next;
    logic        sat_reg, sat_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic signed [31:0] quot_reg, quot_next;
    logic [32:0] trial;
    logic [55:0] num_mag;
    logic [63:0] q_mag;

    // One shift-subtract step per cycle.
    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        num_mag   = num[55] ? 56'(-num) : 56'(num);
        trial     = {rem_reg[31:0], dvd_reg[63]} - {1'b0, dsr_reg};
        q_mag     = dvd_reg;
        if (start)
        begin
            dvd_next  = {num_mag[47:0], 16'd0};
            rem_next  = '0;
            dsr_next  = den[31] ? 32'(-den) : 32'(den);
            neg_next  = num[55] ^ den[31];
            sat_next  = |num_mag[55:47];
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (sat_reg || q_mag > 64'h0000_0000_7FFF_FFFF)
                    quot_next = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                else
                    quot_next = neg_reg ? -$signed(q_mag[31:0]) : $signed(q_mag[31:0]);
            end
            else
            begin
                if (!trial[32])
                begin
                    rem_next = trial;
                    dvd_next = {dvd_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[31:0], dvd_reg[63]};
                    dvd_next = {dvd_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg - 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
        sat_reg  <= sat_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

[rtl/jls_datapath.sv]
// Datapath of the Jacobi solver: stores, multiply-accumulate, divider, change check.
// Depends on jls_pkg and jls_divider.
module jls_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_en,
    input  jls_pkg::in_item_t  load_item,
    input  jls_pkg::dp_cmd_t   cmd,
    input  logic [30:0]        tolerance,
    output jls_pkg::dp_stat_t  stat,
    output logic signed [31:0] out_value
);
    import jls_pkg::*;

    logic signed [31:0] coef_mem [4096];
    logic signed [31:0] rhs_mem  [64];
    logic signed [31:0] cur_mem  [64];
    logic signed [31:0] prev_mem [64];

    logic signed [31:0] a_rd_reg, x_rd_reg, rhs_rd_reg, cur_rd_reg;
    logic signed [63:0] prod_reg;
    logic               prod_v_reg, prod_v2_reg;
    logic signed [55:0] acc_reg, acc_next;
    logic [32:0]        maxchg_reg, maxchg_next;
    logic               zero_reg, zero_next;
    logic [5:0]         div_i_reg;
    logic signed [31:0] prev_i_reg;
    logic               div_done;
    logic signed [31:0] div_q;
    logic signed [32:0] diff;
    logic [32:0]        adiff;
    logic signed [63:0] rounded;

    // Coefficient memory: load writes, solver reads one entry per cycle.
    always_ff @(posedge clk)
    begin
        if (load_en && load_item.req_type == REQ_COEF)
            coef_mem[{load_item.row_index, load_item.col_index}] <= load_item.value;
        if (cmd.diag_rd)
            a_rd_reg <= coef_mem[{cmd.i, cmd.i}];
        else
            a_rd_reg <= coef_mem[{cmd.i, cmd.j}];
    end

    always_ff @(posedge clk)
    begin
        if (load_en && load_item.req_type == REQ_RHS)
            rhs_mem[load_item.row_index] <= load_item.value;
        rhs_rd_reg <= rhs_mem[cmd.i];
    end

    // Previous solution memory, filled by the copy pass.
    always_ff @(posedge clk)
    begin
        if (cmd.copy_wr)
            prev_mem[div_i_reg] <= cur_rd_reg;
        x_rd_reg   <= prev_mem[cmd.j];
        prev_i_reg <= prev_mem[div_i_reg];
    end

    // Current solution memory: loads of the guess and divider results.
    always_ff @(posedge clk)
    begin
        if (load_en && load_item.req_type == REQ_GUESS)
            cur_mem[load_item.row_index] <= load_item.value;
        else if (div_done)
            cur_mem[div_i_reg] <= div_q;
        cur_rd_reg <= cur_mem[cmd.i];
    end

    // Multiplier stage, registered before the accumulate.
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a_rd_reg) * 64'(x_rd_reg);
    end

    assign rounded = (prod_reg + 64'sd32768) >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg  <= 1'b0;
            prod_v2_reg <= 1'b0;
            zero_reg    <= 1'b0;
            maxchg_reg  <= '0;
        end
        else
        begin
            prod_v_reg  <= cmd.mac_rd;
            prod_v2_reg <= prod_v_reg;
            zero_reg    <= zero_next;
            maxchg_reg  <= maxchg_next;
        end
    end

    // Accumulator: rhs minus rounded off-diagonal products, wide enough for 63 terms.
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.row_init)
            acc_next = 56'(rhs_rd_reg);
        else if (prod_v2_reg)
            acc_next = acc_reg - $signed(rounded[55:0]);
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.div_start)
            div_i_reg <= cmd.i;
        else if (cmd.copy_rd)
            div_i_reg <= cmd.i;
    end

    // Zero diagonal detection.
    always_comb
    begin
        zero_next = zero_reg;
        if (cmd.diag_chk)
            zero_next = zero_reg | (a_rd_reg == 32'sd0);
        if (cmd.row_init && cmd.i == 6'd0 && cmd.j == 6'd63)
            zero_next = 1'b0;
    end

    // Largest absolute change, updated as each quotient lands.
    assign diff  = 33'(div_q) - 33'(prev_i_reg);
    assign adiff = diff[32] ? 33'(-diff) : 33'(diff);

    always_comb
    begin
        maxchg_next = maxchg_reg;
        if (cmd.sweep_clr)
            maxchg_next = '0;
        else if (div_done && adiff > maxchg_reg)
            maxchg_next = adiff;
    end

    jls_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (acc_reg),
        .den   (a_rd_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    assign stat.zero_diag = zero_reg;
    assign stat.div_done  = div_done;
    assign stat.converged = (maxchg_reg <= {2'b00, tolerance});
    assign out_value      = cur_rd_reg;
endmodule

[rtl/jls_ctrl.sv]
// Controller state machine for the Jacobi solver: sequences checks, sweeps and output.
// Depends on jls_pkg.
module jls_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [6:0]          order,
    input  logic [15:0]         limit,
    input  jls_pkg::dp_stat_t   stat,
    output jls_pkg::dp_cmd_t    cmd,
    output logic                busy,
    output logic                out_valid,
    output logic [5:0]          out_index,
    output logic [15:0]         sweeps,
    output logic [1:0]          out_status,
    output logic                out_last
);
    import jls_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLRZ   = 4'd1;
    localparam logic [3:0] S_DIAG   = 4'd2;
    localparam logic [3:0] S_DWAIT  = 4'd3;
    localparam logic [3:0] S_COPY   = 4'd4;
    localparam logic [3:0] S_CWAIT  = 4'd5;
    localparam logic [3:0] S_RINIT  = 4'd6;
    localparam logic [3:0] S_MAC    = 4'd7;
    localparam logic [3:0] S_DRAIN  = 4'd8;
    localparam logic [3:0] S_DIVGO  = 4'd9;
    localparam logic [3:0] S_DIVW   = 4'd10;
    localparam logic [3:0] S_DECIDE = 4'd11;
    localparam logic [3:0] S_ORD    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0]  state_reg, state_next;
    logic [5:0]  i_reg, i_next;
    logic [5:0]  j_reg, j_next;
    logic [1:0]  w_reg, w_next;
    logic [15:0] sweeps_reg, sweeps_next;
    logic [1:0]  status_reg, status_next;
    logic        ov_reg, ov_next;
    logic [5:0]  oi_reg, oi_next;
    logic        ol_reg, ol_next;
    logic [5:0]  last_idx;

    // Order in use, clamped to 1..64, as a last index.
    assign last_idx = (order == 7'd0) ? 6'd0 : (order > 7'd64) ? 6'd63 : 6'(order - 7'd1);

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        w_next      = w_reg;
        sweeps_next = sweeps_reg;
        status_next = status_reg;
        ov_next     = 1'b0;
        oi_next     = oi_reg;
        ol_next     = 1'b0;
        cmd         = '0;
        cmd.i       = i_reg;
        cmd.j       = j_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    state_next = S_CLRZ;
                    i_next     = '0;
                end
            end
            S_CLRZ:
            begin
                // Clears the zero flag (row_init at i=0, j=63 marker).
                cmd.j      = 6'd63;
                cmd.row_init = 1'b1;
                state_next = S_DIAG;
            end
            S_DIAG:
            begin
                cmd.diag_rd = 1'b1;
                w_next      = 2'd0;
                state_next  = S_DWAIT;
            end
            S_DWAIT:
            begin
                cmd.diag_chk = 1'b1;
                if (i_reg == last_idx)
                begin
                    state_next  = S_ORD;
                    sweeps_next = '0;
                end
                else
                begin
                    i_next     = i_reg + 6'd1;
                    state_next = S_DIAG;
                end
            end
            S_ORD:
            begin
                i_next = '0;
                if (stat.zero_diag)
                begin
                    status_next = ST_ZERO_DIAG;
                    state_next  = S_OUT;
                end
                else
                    state_next = S_COPY;
            end
            S_COPY:
            begin
                cmd.copy_rd = 1'b1;
                state_next  = S_CWAIT;
            end
            S_CWAIT:
            begin
                cmd.copy_wr = 1'b1;
                if (i_reg == last_idx)
                begin
                    i_next        = '0;
                    cmd.sweep_clr = 1'b1;
                    state_next    = S_RINIT;
                end
                else
                begin
                    i_next     = i_reg + 6'd1;
                    state_next = S_COPY;
                end
            end
            S_RINIT:
            begin
                // The rhs of row i is read now; the accumulator takes it next cycle.
                j_next       = '0;
                state_next   = S_MAC;
            end
            S_MAC:
            begin
                cmd.row_init = (j_reg == 6'd0);
                cmd.mac_rd = (j_reg != i_reg);
                if (j_reg == last_idx)
                begin
                    w_next     = 2'd0;
                    state_next = S_DRAIN;
                end
                else
                    j_next = j_reg + 6'd1;
            end
            S_DRAIN:
            begin
                // Let the multiply pipeline empty; read the diagonal meanwhile.
                cmd.diag_rd = 1'b1;
                w_next      = w_reg + 2'd1;
                if (w_reg == 2'd3)
                    state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    if (i_reg == last_idx)
                    begin
                        sweeps_next = sweeps_reg + 16'd1;
                        state_next  = S_DECIDE;
                    end
                    else
                    begin
                        i_next     = i_reg + 6'd1;
                        state_next = S_RINIT;
                    end
                end
            end
            S_DECIDE:
            begin
                i_next = '0;
                if (stat.converged)
                begin
                    status_next = ST_CONVERGED;
                    state_next  = S_OUT;
                end
                else if (sweeps_reg >= limit)
                begin
                    status_next = ST_LIMIT;
                    state_next  = S_OUT;
                end
                else
                    state_next = S_COPY;
            end
            S_OUT:
            begin
                // x_cur[i] is read now and shown next cycle.
                cmd.out_rd = 1'b1;
                ov_next    = 1'b1;
                oi_next    = i_reg;
                ol_next    = (i_reg == last_idx);
                if (i_reg == last_idx)
                    state_next = S_IDLE;
                else
                    i_next = i_reg + 6'd1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            w_reg      <= '0;
            sweeps_reg <= '0;
            status_reg <= '0;
            ov_reg     <= 1'b0;
            oi_reg     <= '0;
            ol_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            w_reg      <= w_next;
            sweeps_reg <= sweeps_next;
            status_reg <= status_next;
            ov_reg     <= ov_next;
            oi_reg     <= oi_next;
            ol_reg     <= ol_next;
        end
    end

    assign busy       = (state_reg != S_IDLE) || ov_reg;
    assign out_valid  = ov_reg;
    assign out_index  = oi_reg;
    assign sweeps     = sweeps_reg;
    assign out_status = status_reg;
    assign out_last   = ol_reg;
endmodule

[rtl/jacobi_linear_solver.sv]
// Jacobi linear solver, signed Q16.16. Load items are accepted one per cycle while
// the block is not busy. A start item first checks the diagonal for zeros, then runs
// sweeps: a copy pass, n dot products through one multiplier and a bit-serial divide
// per row. Results follow at one per cycle, n items, the receiver cannot stall. Reset
// (async, active low) clears control and sets the registers to 3, 7 and 100; the
// stores are undefined until written.
module jacobi_linear_solver #(
    parameter int MAX_ORDER = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  jls_pkg::in_item_t    in_item,
    output logic                 done,
    output jls_pkg::out_item_t   out_item,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [jls_pkg::CFG_W-1:0] cfg_data
);
    import jls_pkg::*;

    logic [6:0]         order_reg;
    logic [30:0]        tol_reg;
    logic [15:0]        limit_reg;
    logic               accept, load_en, go, ldok;
    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic signed [31:0] out_value;
    logic [5:0]         oi;
    logic [15:0]        sw;
    logic [1:0]         st;
    logic               ol;
    logic [6:0]         ord_use;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 7'd3;
            tol_reg   <= 31'd7;
            limit_reg <= 16'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORDER: order_reg <= cfg_data[6:0];
                CFG_TOL:   tol_reg   <= cfg_data[30:0];
                CFG_LIMIT: limit_reg <= cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    assign accept  = start && !busy;
    assign ldok    = (32'(in_item.row_index) < MAX_ORDER) && (32'(in_item.col_index) < MAX_ORDER
                     || in_item.req_type != REQ_COEF);
    assign load_en = accept && in_item.req_type != REQ_START && ldok;
    assign go      = accept && in_item.req_type == REQ_START;
    assign ord_use = (32'(order_reg) > MAX_ORDER) ? 7'(MAX_ORDER) : order_reg;

    jls_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .order      (ord_use),
        .limit      (limit_reg),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy),
        .out_valid  (done),
        .out_index  (oi),
        .sweeps     (sw),
        .out_status (st),
        .out_last   (ol)
    );

    jls_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (load_en),
        .load_item (in_item),
        .cmd       (cmd),
        .tolerance (tol_reg),
        .stat      (stat),
        .out_value (out_value)
    );

    assign out_item.elem_index  = oi;
    assign out_item.solution    = out_value;
    assign out_item.sweeps_done = sw;
    assign out_item.status      = st;
    assign out_item.last_item   = ol;

    // A result never appears while the block is idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe without busy");
    // The last result ends the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && out_item.last_item |=> !done)
        else $error("result after last item");
    // Zero diagonal status always reports no sweeps.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && out_item.status == ST_ZERO_DIAG |-> out_item.sweeps_done == 16'd0)
        else $error("sweeps with zero diagonal");
endmodule

[test/tb_jacobi_linear_solver.sv]
// Testbench for the Jacobi linear solver: loads systems, starts solves and checks
// every solution item against an in-bench fixed-point predictor.
// Depends on jls_pkg and jacobi_linear_solver from the rtl folder.
`timescale 1ns / 1ps

module tb_jacobi_linear_solver;
    import jls_pkg::*;

    localparam int ORD_MAX = 64;
    localparam longint CYCLE_LIMIT = 5_000_000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    in_item_t          in_item = '0;
    logic              done;
    out_item_t         out_item;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = CFG_ORDER;
    logic [CFG_W-1:0]  cfg_data = '0;

    jacobi_linear_solver #(.MAX_ORDER(ORD_MAX)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .done(done), .out_item(out_item), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Predictor state: the stores and the configuration as the block holds them.
    int          pr_coef [0:ORD_MAX*ORD_MAX-1];
    int          pr_rhs  [0:ORD_MAX-1];
    int          pr_x    [0:ORD_MAX-1];
    logic [6:0]  cf_order = 7'd3;
    logic [30:0] cf_tol = 31'd7;
    logic [15:0] cf_limit = 16'd100;

    // Stimulus side bookkeeping of which entries have been written.
    bit          wr_coef [0:ORD_MAX*ORD_MAX-1];
    bit          wr_rhs  [0:ORD_MAX-1];
    bit          wr_x    [0:ORD_MAX-1];

    in_item_t    pending_items[$];
    out_item_t   expected_solutions[$];
    int          sender_idle_pct = 0;
    int          pushed_items = 0;
    bit          item_taken = 1'b0;
    int          mismatches = 0;
    longint      cycles = 0;

    function automatic int order_in_use();
        if (cf_order < 1) return 1;
        if (cf_order > ORD_MAX) return ORD_MAX;
        return int'(cf_order);
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return int'(v);
    endfunction

    // Q16.16 quotient truncated toward zero, saturated.
    function automatic int q16_quotient(longint num, longint den);
        longint q;
        longint r;
        q = num / den;
        r = num % den;
        if (q > 32768) return 32'h7FFF_FFFF;
        if (q < -32768) return 32'h8000_0000;
        return sat32(q * 65536 + (r * 65536) / den);
    endfunction

    // Apply one accepted item to the predictor; a start queues its solution items.
    task automatic solve_item(in_item_t it);
        int n;
        int st;
        int sweeps;
        bit zdiag;
        int xprev [0:ORD_MAX-1];
        longint acc;
        longint p;
        longint change;
        longint d;
        out_item_t o;
        case (it.req_type)
            REQ_COEF:  pr_coef[it.row_index*ORD_MAX + it.col_index] = it.value;
            REQ_RHS:   pr_rhs[it.row_index] = it.value;
            REQ_GUESS: pr_x[it.row_index] = it.value;
            default:
            begin
                n = order_in_use();
                zdiag = 1'b0;
                sweeps = 0;
                for (int i = 0; i < n; i++)
                    if (pr_coef[i*ORD_MAX + i] == 0) zdiag = 1'b1;
                if (zdiag)
                    st = ST_ZERO_DIAG;
                else
                begin
                    forever
                    begin
                        xprev = pr_x;
                        for (int i = 0; i < n; i++)
                        begin
                            acc = pr_rhs[i];
                            for (int j = 0; j < n; j++)
                                if (j != i)
                                begin
                                    p = longint'(pr_coef[i*ORD_MAX + j]) * longint'(xprev[j]);
                                    acc -= (p + 32768) >>> 16;
                                end
                            pr_x[i] = q16_quotient(acc, pr_coef[i*ORD_MAX + i]);
                        end
                        sweeps++;
                        change = 0;
                        for (int i = 0; i < n; i++)
                        begin
                            d = longint'(pr_x[i]) - longint'(xprev[i]);
                            if (d < 0) d = -d;
                            if (d > change) change = d;
                        end
                        if (change <= longint'(cf_tol))
                        begin
                            st = ST_CONVERGED;
                            break;
                        end
                        if (sweeps >= int'(cf_limit))
                        begin
                            st = ST_LIMIT;
                            break;
                        end
                    end
                end
                for (int i = 0; i < n; i++)
                begin
                    o.elem_index = i[5:0];
                    o.solution = pr_x[i];
                    o.sweeps_done = sweeps[15:0];
                    o.status = st[1:0];
                    o.last_item = (i == n - 1);
                    expected_solutions.push_back(o);
                end
            end
        endcase
    endtask

    // Accept detection, prediction and result checking at the rising edge.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        if (rst_n && start && !busy)
        begin
            solve_item(in_item);
            item_taken = 1'b1;
        end
        if (rst_n && done)
        begin
            if (expected_solutions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected solution item: %p", out_item);
            end
            else
            begin
                out_item_t e;
                e = expected_solutions.pop_front();
                if (out_item.elem_index !== e.elem_index || out_item.solution !== e.solution
                    || out_item.sweeps_done !== e.sweeps_done || out_item.status !== e.status
                    || out_item.last_item !== e.last_item)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("solution mismatch: expected %p got %p", e, out_item);
                end
            end
        end
    end

    // Driver: holds an item until it is taken, then offers the next or idles.
    always @(negedge clk)
    begin
        if (rst_n && (!start || item_taken))
        begin
            item_taken = 1'b0;
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                start <= 1'b1;
                in_item <= pending_items.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    task automatic push_item(logic [1:0] req, int row, int col, int val);
        in_item_t it;
        it.req_type = req;
        it.row_index = row[5:0];
        it.col_index = col[5:0];
        it.value = val;
        pending_items.push_back(it);
        pushed_items++;
        if (req == REQ_COEF) wr_coef[row*ORD_MAX + col] = 1'b1;
        if (req == REQ_RHS) wr_rhs[row] = 1'b1;
        if (req == REQ_GUESS) wr_x[row] = 1'b1;
    endtask

    function automatic int rand_signed(int span);
        return int'($urandom_range(2*span)) - span;
    endfunction

    function automatic int dominant_coef(int n, int row, int col);
        int mag;
        if (row != col) return rand_signed(32768);
        mag = n * 65536 + int'($urandom_range(65535));
        return $urandom_range(1) ? mag : -mag;
    endfunction

    // Loads a full system; noisy systems use full-range coefficients and right-hand sides.
    task automatic load_system(int n, bit noisy);
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
                push_item(REQ_COEF, i, j, noisy ? int'($urandom) : dominant_coef(n, i, j));
            push_item(REQ_RHS, i, 0, noisy ? int'($urandom) : rand_signed(1 << 22));
            push_item(REQ_GUESS, i, 0, $urandom_range(3) == 0 ? int'($urandom)
                                                              : rand_signed(1 << 20));
        end
    endtask

    // Starts a solve after making sure every entry in use has been written.
    task automatic start_solve();
        int n;
        n = order_in_use();
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
                if (!wr_coef[i*ORD_MAX + j]) push_item(REQ_COEF, i, j, dominant_coef(n, i, j));
            if (!wr_rhs[i]) push_item(REQ_RHS, i, 0, rand_signed(1 << 22));
            if (!wr_x[i]) push_item(REQ_GUESS, i, 0, rand_signed(1 << 20));
        end
        push_item(REQ_START, 0, 0, int'($urandom));
    endtask

    // Waits until the block has taken every item and delivered every solution.
    task automatic drain();
        wait (pending_items.size() == 0 && !start && expected_solutions.size() == 0);
        repeat (8) @(posedge clk);
        wait (!busy);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ORDER: cf_order = data[6:0];
            CFG_TOL:   cf_tol = data[30:0];
            default:   cf_limit = data[15:0];
        endcase
    endtask

    task automatic set_regs(int order, int tol, int limit);
        write_reg(CFG_ORDER, CFG_W'(order));
        write_reg(CFG_TOL, CFG_W'(tol));
        write_reg(CFG_LIMIT, CFG_W'(limit));
    endtask

    initial
    begin
        int pct [4];
        int n;
        int phase_start;
        pct = '{0, 74, 0, 29};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, repeated start, zero diagonal.
        load_system(3, 1'b0);
        start_solve();
        start_solve();
        push_item(REQ_COEF, 1, 1, 0);
        start_solve();
        push_item(REQ_COEF, 1, 1, 5 << 16);
        // Order zero clamps to one; a zero iteration limit still runs a sweep.
        set_regs(0, 0, 0);
        start_solve();
        // Widest tolerance with the largest limit converges at once.
        set_regs(1, 32'h7FFF_FFFF, 32'h0000_FFFF);
        start_solve();
        // Tight tolerance with a limit of one stops on the limit.
        set_regs(4, 0, 1);
        load_system(4, 1'b0);
        start_solve();
        // Extreme values over a tiny diagonal saturate the quotient.
        set_regs(2, 7, 3);
        push_item(REQ_COEF, 0, 0, 1);
        push_item(REQ_COEF, 0, 1, 32'h8000_0000);
        push_item(REQ_COEF, 1, 0, 32'h7FFF_FFFF);
        push_item(REQ_COEF, 1, 1, -1);
        push_item(REQ_RHS, 0, 0, 32'h7FFF_FFFF);
        push_item(REQ_RHS, 1, 0, 32'h8000_0000);
        push_item(REQ_GUESS, 0, 0, 32'h8000_0000);
        push_item(REQ_GUESS, 1, 63, 32'h7FFF_FFFF);
        start_solve();

        // Random systems in several sender idling phases.
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            sender_idle_pct = pct[ph];
            phase_start = pushed_items;
            while (pushed_items - phase_start < 55)
            begin
                n = ($urandom_range(9) == 0) ? int'($urandom_range(7, 8))
                                             : int'($urandom_range(1, 6));
                set_regs(n, $urandom_range(3) == 0 ? int'($urandom_range(31'h7FFF_FFFF))
                                                   : int'($urandom_range(64)),
                         $urandom_range(1, 30));
                if ($urandom_range(4) == 0)
                    load_system(n, 1'b1);
                else if ($urandom_range(3) != 0)
                    load_system(n, 1'b0);
                for (int k = 0; k < int'($urandom_range(3)); k++)
                    push_item(2'($urandom_range(2)), $urandom_range(63), $urandom_range(63),
                              int'($urandom));
                start_solve();
                if ($urandom_range(2) == 0) start_solve();
            end
        end

        drain();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_solutions.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
